>>> design/cpe_pkg.sv
// Shared constants, translation tables, types and run-building functions of the encoder.
package cpe_pkg;

	// Printer opcodes
	localparam logic [7:0] OP_START     = 8'h92;
	localparam logic [7:0] OP_SHIFT_ON  = 8'h13;
	localparam logic [7:0] OP_SHIFT_OFF = 8'h12;
	localparam logic [7:0] OP_END       = 8'h22;

	// Escape characters
	localparam logic [6:0] CH_BSLASH = 7'h5c;
	localparam logic [6:0] CH_N      = 7'h6e;
	localparam logic [6:0] CH_B      = 7'h62;
	localparam logic [6:0] CH_R      = 7'h72;
	localparam logic [6:0] CH_LF     = 7'h0a;
	localparam logic [6:0] CH_BS     = 7'h08;
	localparam logic [6:0] CH_CR     = 7'h0d;
	localparam logic [6:0] CH_ZERO   = 7'h30;
	localparam logic [6:0] CH_NINE   = 7'h39;

	// Held digit count codes
	localparam logic [1:0] DH_NONE = 2'd0;
	localparam logic [1:0] DH_ONE  = 2'd1;
	localparam logic [1:0] DH_TWO  = 2'd2;

	// Register indexes
	localparam logic REG_TABLE_SELECT = 1'b0;

	// Longest run of opcodes one request can cause
	localparam int MAX_RUN = 5;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);

	// Translation tables: string table in entries 0..127, plot table in 128..255.
	// Bit 6 of an entry means the code needs shift, bits 5..0 are the code.
	localparam logic [6:0] CODE_ROM [256] = '{
		// string table
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h03, 7'h00, 7'h18, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h42, 7'h69, 7'h55, 7'h7e, 7'h79, 7'h75, 7'h7d, 7'h15,
		7'h70, 7'h71, 7'h7c, 7'h46, 7'h4c, 7'h00, 7'h56, 7'h09,
		7'h31, 7'h29, 7'h36, 7'h3e, 7'h39, 7'h35, 7'h34, 7'h3d,
		7'h3c, 7'h30, 7'h4d, 7'h0d, 7'h00, 7'h06, 7'h00, 7'h49,
		7'h76, 7'h5c, 7'h60, 7'h6c, 7'h6d, 7'h65, 7'h4e, 7'h4f,
		7'h61, 7'h54, 7'h47, 7'h64, 7'h7f, 7'h5f, 7'h66, 7'h59,
		7'h45, 7'h44, 7'h5d, 7'h51, 7'h67, 7'h6e, 7'h5e, 7'h50,
		7'h6f, 7'h41, 7'h77, 7'h00, 7'h00, 7'h00, 7'h00, 7'h40,
		7'h00, 7'h1c, 7'h20, 7'h2c, 7'h2d, 7'h25, 7'h0e, 7'h0f,
		7'h21, 7'h14, 7'h07, 7'h24, 7'h3f, 7'h1f, 7'h26, 7'h19,
		7'h05, 7'h04, 7'h1d, 7'h11, 7'h27, 7'h2e, 7'h1e, 7'h10,
		7'h2f, 7'h01, 7'h37, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		// plot table
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h02, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h15,
		7'h00, 7'h00, 7'h00, 7'h06, 7'h0c, 7'h00, 7'h16, 7'h03,
		7'h31, 7'h29, 7'h36, 7'h3e, 7'h39, 7'h35, 7'h34, 7'h3d,
		7'h3c, 7'h30, 7'h0d, 7'h00, 7'h00, 7'h0a, 7'h00, 7'h09,
		7'h00, 7'h1c, 7'h20, 7'h2c, 7'h2d, 7'h25, 7'h0e, 7'h0f,
		7'h21, 7'h14, 7'h07, 7'h24, 7'h3f, 7'h1f, 7'h26, 7'h19,
		7'h05, 7'h04, 7'h1d, 7'h11, 7'h27, 7'h2e, 7'h1e, 7'h10,
		7'h2f, 7'h01, 7'h37, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h0b, 7'h00, 7'h08, 7'h00, 7'h00
	};

	// One run of opcodes handed from the engine to the output stage
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] codes;
		logic [RUN_W-1:0]        cnt;
	} run_t;

	// Run under construction plus the string flags it changes
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] codes;
		logic [RUN_W-1:0]        cnt;
		logic                    started;
		logic                    shift;
	} acc_t;

	// Engine status seen by the top level
	typedef struct packed {
		logic       started;
		logic       shift;
		logic       esc;
		logic [1:0] digits;
	} eng_stat_t;

	// Output stage status seen by the top level
	typedef struct packed {
		logic             busy;
		logic [RUN_W-1:0] idx;
		logic [RUN_W-1:0] cnt;
	} emit_stat_t;

	function automatic logic [6:0] rom_entry(logic tsel, logic [6:0] ch);
		return CODE_ROM[{tsel, ch}];
	endfunction

	function automatic acc_t acc_push(acc_t a, logic [7:0] code);
		a.codes[a.cnt] = code;
		a.cnt = a.cnt + RUN_W'(1);
		return a;
	endfunction

	// Start marker before the first code of a string
	function automatic acc_t acc_begin(acc_t a);
		if (!a.started) begin
			a.started = 1'b1;
			a = acc_push(a, OP_START);
		end
		return a;
	endfunction

	// Translated character: start marker, shift change, then the low six bits
	function automatic acc_t acc_plain(acc_t a, logic [6:0] entry);
		a = acc_begin(a);
		if (entry[6] && !a.shift) begin
			a.shift = 1'b1;
			a = acc_push(a, OP_SHIFT_ON);
		end else if (!entry[6] && a.shift) begin
			a.shift = 1'b0;
			a = acc_push(a, OP_SHIFT_OFF);
		end
		a = acc_push(a, {2'b00, entry[5:0]});
		return a;
	endfunction

endpackage

>>> design/char_to_printer_code_encoder.sv
// Top level of the character to printer opcode encoder with its configuration port.
//
// Takes one request per cycle while s_tready is high (a character or an end of string on
// s_tuser) and sends the printer opcodes it causes on the master stream, m_tlast marking
// the last opcode of each request. A request goes from the input register through the
// translation logic into a result register that holds its whole run of up to five
// opcodes; the run leaves one opcode per cycle while m_tready is high, and the next
// request is taken in the cycle the last opcode of the current run is taken. Requests
// that cause one opcode stream through at one per cycle while m_tready is high. Requests
// that cause nothing (backslash, held digits) pass without output. table_select
// (register 0, address 0) picks the string or the plot table; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module char_to_printer_code_encoder import cpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] char_code, [7] zero
	input  logic        s_tuser,   // [0] req_type
	// opcode stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] opcode
	output logic        m_tlast,   // last_of_run
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       table_select_q;
	logic       can_load;
	logic       load;
	run_t       run;
	eng_stat_t  eng_stat;
	emit_stat_t emit_stat;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_select_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_SELECT) begin
			table_select_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_TABLE_SELECT) ? {31'b0, table_select_q} : 32'b0;

	cpe_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.tsel     (table_select_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_end   (s_tuser),
		.in_char  (s_tdata[6:0]),
		.can_load (can_load),
		.load     (load),
		.run      (run),
		.stat     (eng_stat)
	);

	cpe_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.run       (run),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (m_tdata),
		.out_last  (m_tlast),
		.stat      (emit_stat)
	);

	// A run in the result register is never empty and its read index stays inside it
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_stat.busy |-> (emit_stat.cnt != '0 && emit_stat.idx < emit_stat.cnt))
		else $error("result run empty or index past its end");

	// A run is not broken off before its last opcode
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("opcode run broken off before its last opcode");

	// An open escape never coexists with held digits
	assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.esc |-> eng_stat.digits == DH_NONE)
		else $error("escape open while digits are held");

	// Shift can only be active inside a started string
	assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.shift |-> eng_stat.started)
		else $error("shift active outside a started string");

endmodule

>>> design/cpe_engine.sv
// Input register, string and escape state, and the logic that builds one run of opcodes.
module cpe_engine import cpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tsel,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_end,
	input  logic [6:0] in_char,
	input  logic      can_load,
	output logic      load,
	output run_t      run,
	output eng_stat_t stat
);

	logic       valid_s1;
	logic       end_s1;
	logic [6:0] ch_s1;

	logic       started_q, shift_q, esc_q;
	logic [1:0] dh_q;
	logic [3:0] d1_q, d2_q;

	logic       esc_d;
	logic [1:0] dh_d;
	logic [3:0] d1_d, d2_d;
	logic       fall;
	acc_t       acc;

	logic       advance;
	logic       is_dig, is_xlat;
	logic [6:0] xlat_ch, main_ch;
	logic [6:0] entry_main, entry_dig;

	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			end_s1 <= in_end;
			ch_s1  <= in_char;
		end
	end

	// Character classes and escape translation
	assign is_dig = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);

	always_comb begin
		is_xlat = 1'b1;
		xlat_ch = ch_s1;
		case (ch_s1)
			CH_N:    xlat_ch = CH_LF;
			CH_B:    xlat_ch = CH_BS;
			CH_R:    xlat_ch = CH_CR;
			default: is_xlat = 1'b0;
		endcase
	end

	assign main_ch    = esc_q ? xlat_ch : ch_s1;
	assign entry_main = rom_entry(tsel, main_ch);
	assign entry_dig  = rom_entry(tsel, {3'b011, d2_q});

	// Run of opcodes and next string state for the request in the input register
	always_comb begin
		acc         = '0;
		acc.started = started_q;
		acc.shift   = shift_q;
		esc_d       = esc_q;
		dh_d        = dh_q;
		d1_d        = d1_q;
		d2_d        = d2_q;
		fall        = 1'b0;
		if (end_s1) begin
			// held second digit goes out as a plain character before the end code
			if (dh_q == DH_TWO && !esc_q) begin
				acc = acc_plain(acc, entry_dig);
			end
			if (acc.started) begin
				acc = acc_push(acc, OP_END);
			end
			acc.started = 1'b0;
			acc.shift   = 1'b0;
			esc_d       = 1'b0;
			dh_d        = DH_NONE;
			d1_d        = '0;
			d2_d        = '0;
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (is_xlat) begin
				acc = acc_plain(acc, entry_main);
			end else if (is_dig) begin
				dh_d = DH_ONE;
				d1_d = ch_s1[3:0];
			end
		end else begin
			fall = 1'b1;
			if (dh_q == DH_ONE) begin
				if (is_dig) begin
					d2_d = ch_s1[3:0];
					dh_d = DH_TWO;
					fall = 1'b0;
				end else begin
					dh_d = DH_NONE;
				end
			end else if (dh_q == DH_TWO) begin
				dh_d = DH_NONE;
				if (is_dig) begin
					// three-digit code, no table and no shift change
					acc  = acc_begin(acc);
					acc  = acc_push(acc, {d1_q[1:0], d2_q[2:0], ch_s1[2:0]});
					fall = 1'b0;
				end else begin
					acc = acc_plain(acc, entry_dig);
				end
			end
			if (fall) begin
				if (ch_s1 == CH_BSLASH) begin
					esc_d = 1'b1;
				end else begin
					acc = acc_plain(acc, entry_main);
				end
			end
		end
	end

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			shift_q   <= 1'b0;
			esc_q     <= 1'b0;
			dh_q      <= DH_NONE;
			d1_q      <= '0;
			d2_q      <= '0;
		end else if (advance) begin
			started_q <= acc.started;
			shift_q   <= acc.shift;
			esc_q     <= esc_d;
			dh_q      <= dh_d;
			d1_q      <= d1_d;
			d2_q      <= d2_d;
		end
	end

	assign load      = advance && (acc.cnt != '0);
	assign run.codes = acc.codes;
	assign run.cnt   = acc.cnt;

	assign stat.started = started_q;
	assign stat.shift   = shift_q;
	assign stat.esc     = esc_q;
	assign stat.digits  = dh_q;

endmodule

>>> design/cpe_emit.sv
// Result register: holds one run of opcodes and sends it out one opcode per cycle while out_ready is high.
module cpe_emit import cpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t       run,
	output logic       can_load,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_code,
	output logic       out_last,
	output emit_stat_t stat
);

	logic                    busy_q;
	logic [MAX_RUN-1:0][7:0] codes_q;
	logic [RUN_W-1:0]        cnt_q;
	logic [RUN_W-1:0]        idx_q;
	logic                    take;

	assign out_valid = busy_q;
	assign out_code  = codes_q[idx_q];
	assign out_last  = (idx_q == cnt_q - RUN_W'(1));
	assign take      = busy_q && out_ready;
	// slot frees up in the cycle its last opcode is taken
	assign can_load  = !busy_q || (take && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + RUN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			codes_q <= run.codes;
			cnt_q   <= run.cnt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.idx  = idx_q;
	assign stat.cnt  = cnt_q;

endmodule
